>>> hdl/sid_pkg.sv
`timescale 1ns / 1ps

package sid_pkg;

  // default field widths
  localparam int ACCEL_WIDTH = 16;
  localparam int TIME_WIDTH  = 32;

  // fixed widths of registers and result fields
  localparam int LEVEL_W    = 20;
  localparam int WAKE_W     = 16;
  localparam int DUR_W      = 16;
  localparam int DELAY_W    = 24;
  localparam int DECAY_W    = 16;
  localparam int OP_W       = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_DATA_W = 24;

  // magnitude register must also hold its one-g reset value
  localparam int MAG_MIN_W = 13;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // item kinds
  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_MODE   = 2'd2,
    OP_POKE   = 2'd3
  } op_t;

  // operating modes
  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUSY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WAIT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_JERK       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIZZY_DURATION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_DELAY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR    = 3'd4;

  // register reset values
  localparam logic [LEVEL_W-1:0] RST_SHAKE_THRESHOLD = 20'd28672;
  localparam logic [WAKE_W-1:0]  RST_WAKE_JERK       = 16'd492;
  localparam logic [DUR_W-1:0]   RST_DIZZY_DURATION  = 16'd2200;
  localparam logic [DELAY_W-1:0] RST_SLEEP_DELAY     = 24'd20000;
  localparam logic [DECAY_W-1:0] RST_DECAY_FACTOR    = 16'd52429;

  // one g in Q4.12
  localparam int MAG_RESET = 4096;

endpackage

>>> hdl/sid_isqrt.sv
`timescale 1ns / 1ps

// digit-by-digit integer square root, one root bit per cycle
module sid_isqrt #(
  parameter int RW = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic            done,
  output logic [RW-1:0]   root
);

  localparam int CW = $clog2(RW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [2*RW-1:0] n_r;
  logic [RW-1:0]   rem_r;
  logic [RW-1:0]   root_r;

  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic            ge;
  logic [RW+1:0]   rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, n_r[2*RW-1 -: 2]};
    trial   = {root_r, 2'b01};
    ge      = rem_sh >= trial;
    rem_nxt = ge ? rem_sh - trial : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r    <= {n_r[2*RW-3:0], 2'b00};
      rem_r  <= rem_nxt[RW-1:0];
      root_r <= {root_r[RW-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> hdl/shake_and_inactivity_detector_top.sv
`timescale 1ns / 1ps

// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  tuser: operation; tdata: accel x,y,z, time_ms, new_mode
// out_     out  out_tvalid/out_tready tdata: sleeping, dizzy, dizzy_started, shake_level
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (ready whenever out of reset)
//
// a sample runs the square, root, decay, jerk and finish states: three squares on the
// shared multiplier, ACCEL_WIDTH steps of the square root unit, one decay product, then
// the saturated level sum and state update; tick, mode change and poke skip to finish
// in_tready is high only while the sequencer is idle and rst_n is high
// a finished result waits in the output register; a new item is taken meanwhile, and
// its result holds in the finish state until the output register frees
// rst_n is synchronous: registers take their reset values, no transfer is pending

module shake_and_inactivity_detector_top #(
  parameter int ACCEL_WIDTH = sid_pkg::ACCEL_WIDTH,
  parameter int TIME_WIDTH  = sid_pkg::TIME_WIDTH,
  localparam int IN_DATA_W  = ((3 * ACCEL_WIDTH + TIME_WIDTH + sid_pkg::MODE_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // accel_x, accel_y, accel_z, time_ms, new_mode, zero pad
  input  logic [IN_DATA_W-1:0]           in_tdata,
  // operation
  input  logic [sid_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // sleeping, dizzy, dizzy_started, shake_level, zero pad
  output logic [sid_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sid_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW      = ACCEL_WIDTH;
  localparam int TW      = TIME_WIDTH;
  localparam int LW      = sid_pkg::LEVEL_W;
  localparam int SUM_W   = 2 * AW;
  localparam int MAG_W   = (AW > sid_pkg::MAG_MIN_W) ? AW : sid_pkg::MAG_MIN_W;
  localparam int MUL_AW  = (AW > LW) ? AW : LW;
  localparam int MUL_BW  = (AW > sid_pkg::DECAY_W) ? AW : sid_pkg::DECAY_W;
  localparam int PROD_W  = MUL_AW + MUL_BW;
  localparam int ACC_S_W = ((MAG_W > LW) ? MAG_W : LW) + 1;
  localparam int JW      = (MAG_W > sid_pkg::WAKE_W) ? MAG_W : sid_pkg::WAKE_W;
  localparam int IW      = (TW > sid_pkg::DELAY_W) ? TW : sid_pkg::DELAY_W;
  localparam int MODE_W  = sid_pkg::MODE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_DECAY,
    S_JERK,
    S_FINISH
  } state_t;

  state_t state_r;

  // configuration registers
  logic [LW-1:0]                thr_r;
  logic [sid_pkg::WAKE_W-1:0]   wake_r;
  logic [sid_pkg::DUR_W-1:0]    dur_r;
  logic [sid_pkg::DELAY_W-1:0]  delay_r;
  logic [sid_pkg::DECAY_W-1:0]  decay_r;

  // detector state
  logic [MAG_W-1:0]  prev_r,   prev_nxt;
  logic [LW-1:0]     acc_r,    acc_nxt;
  logic [TW-1:0]     dz_end_r, dz_end_nxt;
  logic [TW-1:0]     last_r,   last_nxt;
  logic              asleep_r, asleep_nxt;
  logic [MODE_W-1:0] mode_r,   mode_nxt;

  // captured item
  sid_pkg::op_t      op_r;
  logic [AW-1:0]     abs_r [3];
  logic [TW-1:0]     time_r;
  logic [MODE_W-1:0] new_mode_r;

  // datapath
  logic [1:0]        cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic [PROD_W-1:0] prod_r;
  logic [MAG_W-1:0]  jerk_r;
  logic [LW-1:0]     acc_sat_r;

  logic              out_tvalid_r;
  logic              out_sleep_r;
  logic              out_dizzy_r;
  logic              out_started_r;
  logic [LW-1:0]     out_level_r;

  logic [AW-1:0]     raw_x, raw_y, raw_z;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              sqrt_start;
  logic              sqrt_done;
  logic [AW-1:0]     sqrt_root;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  jerk_nxt;
  logic [ACC_S_W-1:0] acc_sum;
  logic              out_free;
  logic              started;
  logic              dz_now;
  logic [TW-1:0]     idle_time;
  logic [MODE_W-1:0] mode_req;

  // nothing is taken while rst_n is low
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign cfg_ready = rst_n;
  assign out_free  = !out_tvalid_r || out_tready;

  assign raw_x = in_tdata[0 +: AW];
  assign raw_y = in_tdata[AW +: AW];
  assign raw_z = in_tdata[2*AW +: AW];

  // shared multiplier: squares during sampling, decay product afterwards
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SQUARE) begin
      case (cnt_r)
        2'd0:    begin mul_a = MUL_AW'(abs_r[0]); mul_b = MUL_BW'(abs_r[0]); end
        2'd1:    begin mul_a = MUL_AW'(abs_r[1]); mul_b = MUL_BW'(abs_r[1]); end
        2'd2:    begin mul_a = MUL_AW'(abs_r[2]); mul_b = MUL_BW'(abs_r[2]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == S_DECAY) begin
      mul_a = MUL_AW'(acc_r);
      mul_b = MUL_BW'(decay_r);
    end
    mul_p = mul_a * mul_b;
  end

  assign sqrt_start = (state_r == S_ROOT_GO);

  sid_isqrt #(
    .RW (AW)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sum_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // jerk against the previous magnitude, and the leaky accumulator sum
  always_comb begin
    mag      = MAG_W'(sqrt_root);
    jerk_nxt = (mag >= prev_r) ? mag - prev_r : prev_r - mag;
    acc_sum  = ACC_S_W'(prod_r[16 +: LW]) + ACC_S_W'(jerk_r);
  end

  // state update for the finished item
  always_comb begin
    prev_nxt   = prev_r;
    acc_nxt    = acc_r;
    dz_end_nxt = dz_end_r;
    last_nxt   = last_r;
    asleep_nxt = asleep_r;
    mode_nxt   = mode_r;
    started    = 1'b0;
    dz_now     = time_r < dz_end_r;
    idle_time  = (time_r > last_r) ? time_r - last_r : '0;
    // the unused mode code counts as idle
    mode_req   = (new_mode_r == sid_pkg::MODE_BUSY || new_mode_r == sid_pkg::MODE_WAIT) ?
                 new_mode_r : sid_pkg::MODE_IDLE;
    case (op_r)
      sid_pkg::OP_SAMPLE: begin
        prev_nxt = mag;
        acc_nxt  = acc_sat_r;
        if (acc_sat_r > thr_r && time_r >= dz_end_r) begin
          // strong shake: open the dizzy window and wake
          dz_end_nxt = time_r + TW'(dur_r);
          acc_nxt    = '0;
          started    = 1'b1;
          last_nxt   = time_r;
          asleep_nxt = 1'b0;
        end else if (asleep_r && JW'(jerk_r) > JW'(wake_r)) begin
          last_nxt   = time_r;
          asleep_nxt = 1'b0;
        end
      end
      sid_pkg::OP_TICK: begin
        if (mode_r != sid_pkg::MODE_IDLE || dz_now) begin
          last_nxt   = time_r;
          asleep_nxt = 1'b0;
        end else if (!asleep_r && IW'(idle_time) > IW'(delay_r)) begin
          asleep_nxt = 1'b1;
        end
      end
      sid_pkg::OP_MODE: begin
        if (mode_req != mode_r) begin
          mode_nxt = mode_req;
          if (mode_req != sid_pkg::MODE_IDLE) begin
            last_nxt   = time_r;
            asleep_nxt = 1'b0;
          end
        end
      end
      sid_pkg::OP_POKE: begin
        last_nxt   = time_r;
        asleep_nxt = 1'b0;
      end
      default: begin
        last_nxt = last_r;
      end
    endcase
  end

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= sid_pkg::RST_SHAKE_THRESHOLD;
      wake_r  <= sid_pkg::RST_WAKE_JERK;
      dur_r   <= sid_pkg::RST_DIZZY_DURATION;
      delay_r <= sid_pkg::RST_SLEEP_DELAY;
      decay_r <= sid_pkg::RST_DECAY_FACTOR;
    end else if (cfg_valid) begin
      case (cfg_index)
        sid_pkg::CFG_SHAKE_THRESHOLD: thr_r   <= cfg_data[LW-1:0];
        sid_pkg::CFG_WAKE_JERK:       wake_r  <= cfg_data[sid_pkg::WAKE_W-1:0];
        sid_pkg::CFG_DIZZY_DURATION:  dur_r   <= cfg_data[sid_pkg::DUR_W-1:0];
        sid_pkg::CFG_SLEEP_DELAY:     delay_r <= cfg_data[sid_pkg::DELAY_W-1:0];
        sid_pkg::CFG_DECAY_FACTOR:    decay_r <= cfg_data[sid_pkg::DECAY_W-1:0];
        default:                      thr_r   <= thr_r;
      endcase
    end
  end

  // sequencer, detector state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_tvalid_r  <= 1'b0;
      out_sleep_r   <= 1'b0;
      out_dizzy_r   <= 1'b0;
      out_started_r <= 1'b0;
      out_level_r   <= '0;
      prev_r        <= MAG_W'(sid_pkg::MAG_RESET);
      acc_r         <= '0;
      dz_end_r      <= '0;
      last_r        <= '0;
      asleep_r      <= 1'b0;
      mode_r        <= sid_pkg::MODE_IDLE;
    end else begin
      // the finish state reloads the output register itself
      if (state_r != S_FINISH && out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= (sid_pkg::op_t'(in_tuser) == sid_pkg::OP_SAMPLE) ? S_SQUARE : S_FINISH;
          end
        end
        S_SQUARE: begin
          if (cnt_r == 2'd3) state_r <= S_ROOT_GO;
        end
        S_ROOT_GO: begin
          state_r <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (sqrt_done) state_r <= S_DECAY;
        end
        S_DECAY: begin
          state_r <= S_JERK;
        end
        S_JERK: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            prev_r        <= prev_nxt;
            acc_r         <= acc_nxt;
            dz_end_r      <= dz_end_nxt;
            last_r        <= last_nxt;
            asleep_r      <= asleep_nxt;
            mode_r        <= mode_nxt;
            out_tvalid_r  <= 1'b1;
            out_sleep_r   <= asleep_nxt;
            out_dizzy_r   <= time_r < dz_end_nxt;
            out_started_r <= started;
            out_level_r   <= acc_nxt;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        op_r       <= sid_pkg::op_t'(in_tuser);
        abs_r[0]   <= raw_x[AW-1] ? ~raw_x + 1'b1 : raw_x;
        abs_r[1]   <= raw_y[AW-1] ? ~raw_y + 1'b1 : raw_y;
        abs_r[2]   <= raw_z[AW-1] ? ~raw_z + 1'b1 : raw_z;
        time_r     <= in_tdata[3*AW +: TW];
        new_mode_r <= in_tdata[3*AW+TW +: MODE_W];
        cnt_r      <= '0;
        sum_r      <= '0;
      end
      S_SQUARE: begin
        // multiply one axis while the previous square is added
        cnt_r  <= cnt_r + 1'b1;
        prod_r <= mul_p;
        if (cnt_r != 2'd0) sum_r <= sum_r + prod_r[SUM_W-1:0];
      end
      S_DECAY: begin
        prod_r <= mul_p;
        jerk_r <= jerk_nxt;
      end
      S_JERK: begin
        acc_sat_r <= (acc_sum > ACC_S_W'(sid_pkg::LEVEL_MAX)) ?
                     sid_pkg::LEVEL_MAX : acc_sum[LW-1:0];
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_level_r, out_started_r, out_dizzy_r, out_sleep_r};

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sid_pkg::*;

  localparam int IN_DATA_W   = ((3 * ACCEL_WIDTH + TIME_WIDTH + MODE_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_DATA_W - 3 * ACCEL_WIDTH - TIME_WIDTH - MODE_W;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 275;
  // sample cost at default width plus margin, used before register writes and at the end
  localparam int SETTLE      = 40;
  // mode code three, read by the block as idle
  localparam logic [MODE_W-1:0] MODE_ALIAS = 2'd3;

  typedef longint unsigned u64_t;

  // one input transfer, fields as the block sees them
  typedef struct {
    op_t                    op;
    logic [ACCEL_WIDTH-1:0] x;
    logic [ACCEL_WIDTH-1:0] y;
    logic [ACCEL_WIDTH-1:0] z;
    logic [TIME_WIDTH-1:0]  stamp;
    logic [MODE_W-1:0]      mode;
  } item_t;

  // result word from bit 0 up: sleeping, dizzy, dizzy_started, shake_level
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               started;
    logic               dizzy;
    logic               sleeping;
  } status_t;

  // tracks detector state and the queue of status words still owed by the block
  class detector_scoreboard;
    bit [LEVEL_W-1:0]    threshold;
    bit [WAKE_W-1:0]     wake_level;
    bit [DUR_W-1:0]      dizzy_len;
    bit [DELAY_W-1:0]    sleep_after;
    bit [DECAY_W-1:0]    decay;
    bit [16:0]           prev_mag;
    bit [LEVEL_W-1:0]    level;
    bit [TIME_WIDTH-1:0] dizzy_end;
    bit [TIME_WIDTH-1:0] last_active;
    bit                  asleep;
    bit [MODE_W-1:0]     mode;
    status_t             owed_q[$];
    int                  mismatches;

    function new();
      threshold   = RST_SHAKE_THRESHOLD;
      wake_level  = RST_WAKE_JERK;
      dizzy_len   = RST_DIZZY_DURATION;
      sleep_after = RST_SLEEP_DELAY;
      decay       = RST_DECAY_FACTOR;
      prev_mag    = 17'(MAG_RESET);
      level       = '0;
      dizzy_end   = '0;
      last_active = '0;
      asleep      = 1'b0;
      mode        = MODE_IDLE;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SHAKE_THRESHOLD: threshold   = val[LEVEL_W-1:0];
        CFG_WAKE_JERK:       wake_level  = val[WAKE_W-1:0];
        CFG_DIZZY_DURATION:  dizzy_len   = val[DUR_W-1:0];
        CFG_SLEEP_DELAY:     sleep_after = val[DELAY_W-1:0];
        CFG_DECAY_FACTOR:    decay       = val[DECAY_W-1:0];
        default: ;
      endcase
    endfunction

    function u64_t square(logic [ACCEL_WIDTH-1:0] raw);
      int   v;
      u64_t a;
      v = int'($signed(raw));
      a = (v < 0) ? u64_t'(-v) : u64_t'(v);
      return a * a;
    endfunction

    // bitwise integer square root, floor
    function bit [16:0] root_of(u64_t n);
      bit [16:0] r;
      bit [16:0] t;
      u64_t      sq;
      r = '0;
      for (int b = 16; b >= 0; b--) begin
        t  = r | (17'd1 << b);
        sq = u64_t'(t);
        if (sq * sq <= n) r = t;
      end
      return r;
    endfunction

    function void mark_active(bit [TIME_WIDTH-1:0] now);
      last_active = now;
      asleep      = 1'b0;
    endfunction

    function void note_input(item_t it);
      status_t             r;
      bit [16:0]           mag;
      bit [16:0]           jerk;
      u64_t                acc;
      bit [TIME_WIDTH-1:0] idle;
      bit [MODE_W-1:0]     m;
      r = '0;
      case (it.op)
        OP_SAMPLE: begin
          mag      = root_of(square(it.x) + square(it.y) + square(it.z));
          jerk     = (mag >= prev_mag) ? mag - prev_mag : prev_mag - mag;
          prev_mag = mag;
          acc      = ((u64_t'(level) * u64_t'(decay)) >> 16) + jerk;
          level    = (acc > u64_t'(LEVEL_MAX)) ? LEVEL_MAX : acc[LEVEL_W-1:0];
          if (level > threshold && it.stamp >= dizzy_end) begin
            dizzy_end = it.stamp + dizzy_len;
            level     = '0;
            r.started = 1'b1;
            mark_active(it.stamp);
          end else if (asleep && jerk > wake_level) begin
            mark_active(it.stamp);
          end
        end
        OP_TICK: begin
          idle = (it.stamp > last_active) ? it.stamp - last_active : '0;
          if (mode != MODE_IDLE || it.stamp < dizzy_end) mark_active(it.stamp);
          else if (!asleep && idle > sleep_after) asleep = 1'b1;
        end
        OP_MODE: begin
          m = (it.mode == MODE_ALIAS) ? MODE_IDLE : it.mode;
          if (m != mode) begin
            mode = m;
            if (m != MODE_IDLE) mark_active(it.stamp);
          end
        end
        default: mark_active(it.stamp);
      endcase
      r.sleeping = asleep;
      r.dizzy    = it.stamp < dizzy_end;
      r.level    = level;
      owed_q.push_back(r);
    endfunction

    function void report(string what, status_t want, status_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $write("%s: expected sleeping=%0d dizzy=%0d started=%0d level=%0d, ",
               what, want.sleeping, want.dizzy, want.started, want.level);
        $display("got sleeping=%0d dizzy=%0d started=%0d level=%0d",
                 got.sleeping, got.dizzy, got.started, got.level);
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      status_t got;
      status_t want;
      got = data[$bits(status_t)-1:0];
      if (owed_q.size() == 0) begin
        report("result with nothing owed", '0, got);
        return;
      end
      want = owed_q.pop_front();
      if (got.sleeping !== want.sleeping || got.dizzy !== want.dizzy ||
          got.started !== want.started || got.level !== want.level)
        report("status mismatch", want, got);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  // every input known from time zero
  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // accel_x, accel_y, accel_z, time_ms, new_mode, zero pad
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // operation
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // sleeping, dizzy, dizzy_started, shake_level, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  detector_scoreboard    sb;
  int                    cycles     = 0;
  // when set, neither side idles or stalls
  bit                    steady     = 1'b0;
  // running millisecond clock for the well-formed sequences
  logic [TIME_WIDTH-1:0] now_ms     = '0;

  shake_and_inactivity_detector_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls about a quarter of the cycles unless steady
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 24);
  end

  // values seen here are the ones present at the edge, so the transfer is real
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // one input transfer; tvalid stays high into the next item unless a gap is taken
  task automatic put(op_t op, logic [ACCEL_WIDTH-1:0] x, logic [ACCEL_WIDTH-1:0] y,
                     logic [ACCEL_WIDTH-1:0] z, logic [TIME_WIDTH-1:0] stamp,
                     logic [MODE_W-1:0] mode);
    item_t it;
    it = '{op: op, x: x, y: y, z: z, stamp: stamp, mode: mode};
    if (!steady && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 24);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{IN_PAD_W{1'b0}}, mode, stamp, z, y, x};
    do @(posedge clk); while (!in_tready);
    sb.note_input(it);
  endtask

  function automatic logic [ACCEL_WIDTH-1:0] wobble(int centre, int span);
    return ACCEL_WIDTH'(centre + int'($urandom_range(2 * span)) - span);
  endfunction

  // roughly one g on z with noise, sign of gravity random
  task automatic put_rest(int span);
    int g;
    g = $urandom_range(1) ? 4096 : -4096;
    now_ms += $urandom_range(5, 60);
    put(OP_SAMPLE, wobble(0, span / 4), wobble(0, span / 4), wobble(g, span), now_ms,
        MODE_W'($urandom));
  endtask

  // register writes happen only with the block drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] th, logic [CFG_DATA_W-1:0] wj,
                              logic [CFG_DATA_W-1:0] dd, logic [CFG_DATA_W-1:0] sd,
                              logic [CFG_DATA_W-1:0] df, bit spare);
    write_reg(CFG_SHAKE_THRESHOLD, th);
    write_reg(CFG_WAKE_JERK, wj);
    write_reg(CFG_DIZZY_DURATION, dd);
    write_reg(CFG_SLEEP_DELAY, sd);
    write_reg(CFG_DECAY_FACTOR, df);
    // unmapped indexes must leave everything alone
    if (spare)
      for (int i = int'(CFG_DECAY_FACTOR) + 1; i < (1 << CFG_IDX_W); i++)
        write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // stop sending, collect every owed status, then let the block go quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly well-formed sequences: shake bursts, gentle motion, sleep and wake
  task automatic run_random(int count);
    int   sent;
    int   pick;
    int   n;
    int   span;
    u64_t reach;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      span = (sb.wake_level + 64 > 2000) ? 2000 : sb.wake_level + 64;
      // now and then jump close to the time wrap
      if ($urandom_range(99) == 0) now_ms = '1 - $urandom_range(5000);
      if (pick < 30) begin
        // shake burst, random vectors over the full range between resting ones
        n = $urandom_range(2, 6);
        for (int k = 0; k < n; k++) begin
          if (k % 2 == 0) begin
            now_ms += $urandom_range(5, 60);
            put(OP_SAMPLE, ACCEL_WIDTH'($urandom), ACCEL_WIDTH'($urandom),
                ACCEL_WIDTH'($urandom), now_ms, MODE_W'($urandom));
          end else begin
            put_rest(span);
          end
        end
        sent += n;
      end else if (pick < 55) begin
        // gentle motion around the wake threshold
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) put_rest(span);
        sent += n;
      end else if (pick < 70) begin
        // go idle, wait about the sleep delay, tick, maybe nudge awake
        now_ms += $urandom_range(1, 50);
        put(OP_MODE, ACCEL_WIDTH'($urandom), ACCEL_WIDTH'($urandom), ACCEL_WIDTH'($urandom),
            now_ms, $urandom_range(1) ? MODE_IDLE : MODE_ALIAS);
        reach = u64_t'(sb.sleep_after) + u64_t'(sb.sleep_after / 2) + 50;
        now_ms += $urandom_range(0, 32'(reach));
        put(OP_TICK, ACCEL_WIDTH'($urandom), ACCEL_WIDTH'($urandom), ACCEL_WIDTH'($urandom),
            now_ms, MODE_W'($urandom));
        sent += 2;
        if ($urandom_range(1)) begin
          put_rest(span * 2);
          sent++;
        end
      end else if (pick < 80) begin
        // mode change, often followed by a tick
        now_ms += $urandom_range(1, 500);
        put(OP_MODE, ACCEL_WIDTH'($urandom), ACCEL_WIDTH'($urandom), ACCEL_WIDTH'($urandom),
            now_ms, MODE_W'($urandom));
        sent++;
        if ($urandom_range(1)) begin
          now_ms += $urandom_range(1, 3000);
          put(OP_TICK, ACCEL_WIDTH'($urandom), ACCEL_WIDTH'($urandom),
              ACCEL_WIDTH'($urandom), now_ms, MODE_W'($urandom));
          sent++;
        end
      end else if (pick < 88) begin
        now_ms += $urandom_range(1, 200);
        put(OP_POKE, ACCEL_WIDTH'($urandom), ACCEL_WIDTH'($urandom), ACCEL_WIDTH'($urandom),
            now_ms, MODE_W'($urandom));
        sent++;
      end else begin
        // noise: every field random, time anywhere
        put(op_t'($urandom_range(3)), ACCEL_WIDTH'($urandom), ACCEL_WIDTH'($urandom),
            ACCEL_WIDTH'($urandom), TIME_WIDTH'($urandom), MODE_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk with reset register values
    put(OP_SAMPLE, 16'd0, 16'd0, 16'd4096, 32'd0, MODE_IDLE);                 // at rest
    put(OP_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd10, MODE_IDLE);          // full scale, dizzy
    put(OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'd20, MODE_IDLE);          // most negative
    put(OP_SAMPLE, 16'd0, 16'd0, 16'd0, 32'd30, MODE_IDLE);                   // big jerk in window
    put(OP_TICK, 16'd0, 16'd0, 16'd0, 32'd40, MODE_IDLE);                     // dizzy tick pokes
    put(OP_MODE, 16'd0, 16'd0, 16'd0, 32'd50, MODE_BUSY);
    put(OP_MODE, 16'd0, 16'd0, 16'd0, 32'd60, MODE_BUSY);                     // same mode, no-op
    put(OP_TICK, 16'd0, 16'd0, 16'd0, 32'd70, MODE_IDLE);                     // busy tick pokes
    put(OP_MODE, 16'd0, 16'd0, 16'd0, 32'd80, MODE_WAIT);
    put(OP_MODE, 16'd0, 16'd0, 16'd0, 32'd90, MODE_ALIAS);                    // code three is idle
    put(OP_MODE, 16'd0, 16'd0, 16'd0, 32'd100, MODE_IDLE);
    put(OP_POKE, 16'd0, 16'd0, 16'd0, 32'd110, MODE_IDLE);
    put(OP_SAMPLE, 16'd0, 16'd0, 16'd0, 32'd2300, MODE_IDLE);                 // second window
    put(OP_TICK, 16'd0, 16'd0, 16'd0, 32'd3000, MODE_IDLE);
    put(OP_TICK, 16'd0, 16'd0, 16'd0, 32'd40000, MODE_IDLE);                  // falls asleep
    put(OP_SAMPLE, 16'd0, 16'd0, 16'd0, 32'd40010, MODE_IDLE);                // no jerk
    put(OP_SAMPLE, 16'd0, 16'd0, 16'd300, 32'd40020, MODE_IDLE);              // below wake jerk
    put(OP_SAMPLE, 16'd0, 16'd0, 16'd1000, 32'd40030, MODE_IDLE);             // wakes
    put(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0, MODE_ALIAS);    // asleep again
    put(OP_POKE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, MODE_ALIAS);
    put(OP_TICK, 16'd0, 16'd0, 16'd0, 32'd5, MODE_IDLE);                      // time went back
    put(OP_SAMPLE, 16'h7FFF, 16'h8000, 16'h7FFF, 32'hFFFF_FF00, MODE_IDLE);   // window wraps
    put(OP_TICK, 16'd0, 16'd0, 16'd0, 32'h100, MODE_IDLE);
    put(OP_MODE, 16'd0, 16'd0, 16'd0, 32'h200, MODE_WAIT);
    put(OP_TICK, 16'd0, 16'd0, 16'd0, 32'h300, MODE_IDLE);                    // waiting tick pokes
    now_ms = 32'h1000;
    run_random(PHASE_ITEMS);
    drain();

    // all registers at their minimum
    program_regs('0, '0, '0, '0, '0, 1'b0);
    run_random(PHASE_ITEMS);
    drain();

    // all registers at their maximum, with no idling on either side
    steady = 1'b1;
    program_regs('1, '1, '1, '1, '1, 1'b0);
    run_random(PHASE_ITEMS);
    drain();
    steady = 1'b0;

    // moderate values with short windows and sleep delay
    program_regs(24'd20000, 24'd300, 24'd500, 24'd3000, 24'd60000, 1'b1);
    run_random(PHASE_ITEMS);
    drain();

    // random values, upper data bits included
    program_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                 CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b1);
    run_random(PHASE_ITEMS);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
